// ===== rtl/amsa_pkg.sv =====
// Shared types and constants for the analog mux scan accumulator.
// No dependencies; imported by analog_mux_scan_accumulator_top.
package amsa_pkg;

  // Field and storage widths
  localparam int ACC_W       = 15;
  localparam int ACC_DEPTH   = 64;
  localparam int ACC_AW      = 6;
  localparam int SAMPLE_W    = 10;
  localparam int PASS_W      = 6;
  localparam int SHIFT_W     = 3;
  localparam int MUX_W       = 3;
  localparam int INP_W       = 4;
  localparam int CFG_DATA_W  = 6;
  localparam int CFG_IDX_W   = 1;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // Parameter defaults
  localparam int NUM_MUX_DEF    = 4;
  localparam int MUX_INPUTS_DEF = 16;
  localparam int ADC_BITS_DEF   = 10;

  // Register reset values
  localparam logic [PASS_W-1:0]  PASSES_RST = 6'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_RST  = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PASSES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SHIFT  = 1'd1;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  // Memory operation carried into the write-back stage
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_READ = 2'd2
  } op_t;

endpackage

// ===== rtl/analog_mux_scan_accumulator_top.sv =====
// Pipeline: an accepted request reads the accumulator memory into stage 1; stage 1 then
// modifies the entry and loads the output register.
// Throughput: one request per cycle; the accumulator memory read port and the
// single write-back stage set that rate; a stalled output holds the pipe.
// Reset: synchronous, active high; clears scan counters, per-entry valid bits
// (accumulators read as zero until written) and the pipe; no clearing pass.
module analog_mux_scan_accumulator_top
  import amsa_pkg::*;
#(
  parameter int NUM_MUX    = NUM_MUX_DEF,
  parameter int MUX_INPUTS = MUX_INPUTS_DEF,
  parameter int ADC_BITS   = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            command,
  input  logic [SAMPLE_W-1:0]   sample,
  input  logic [ACC_AW-1:0]     channel,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ACC_W-1:0]      read_value,
  output logic                  data_available,
  output logic                  start_conversion,
  output logic [MUX_W-1:0]      mux_select,
  output logic [INP_W-1:0]      mux_input_select
);

  // Sample mask: keep only the converter's ADC_BITS low bits.
  localparam int SMASK_INT = (ADC_BITS >= SAMPLE_W) ? ((1 << SAMPLE_W) - 1)
                                                    : ((1 << ADC_BITS) - 1);
  localparam logic [SAMPLE_W-1:0] SMASK = SMASK_INT[SAMPLE_W-1:0];

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PASS_W-1:0]  sample_passes;
  logic [SHIFT_W-1:0] sample_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_passes <= PASSES_RST;
      sample_shift  <= SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_PASSES: sample_passes <= cfg_data[PASS_W-1:0];
        REG_SAMPLE_SHIFT:  sample_shift  <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Scan state (scalar, updated at request accept)
  // ---------------------------------------------------------------------------
  logic [ACC_AW-1:0] channel_index, channel_index_next;
  logic [MUX_W-1:0]  active_mux, active_mux_next;
  logic [INP_W-1:0]  active_mux_input, active_mux_input_next;
  logic [PASS_W-1:0] pass_count, pass_count_next;
  logic              discard_next, discard_next_next;

  // Pipeline handshake
  logic s1_valid;
  logic s1_adv;
  logic accept;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  // Decoded request, stage 0
  cmd_t              cmd;
  op_t               s0_op;
  logic [ACC_AW-1:0] s0_addr;
  logic              s0_start;
  logic              s0_avail;
  logic              stopped;
  logic [INP_W-1:0]  inp_inc;
  logic [MUX_W-1:0]  mux_inc;
  logic              inp_wrap;
  logic              mux_wrap;

  assign cmd     = cmd_t'(command);
  assign stopped = pass_count >= sample_passes;
  assign inp_inc = active_mux_input + 1'b1;
  assign mux_inc = active_mux + 1'b1;
  // Out-of-range counts as the end of the mux or of the pass.
  assign inp_wrap = (int'(inp_inc) >= MUX_INPUTS) || (inp_inc == '0);
  assign mux_wrap = (int'(mux_inc) >= NUM_MUX) || (mux_inc == '0);

  always_comb begin
    channel_index_next    = channel_index;
    active_mux_next       = active_mux;
    active_mux_input_next = active_mux_input;
    pass_count_next       = pass_count;
    discard_next_next     = discard_next;
    s0_op                 = OP_NONE;
    s0_addr               = channel;
    s0_start              = 1'b0;
    case (cmd)
      CMD_SAMPLE: begin
        if (!stopped) begin
          discard_next_next = !discard_next;
          if (!discard_next) begin
            // kept reading: accumulate into current channel, then advance
            s0_op              = OP_ADD;
            s0_addr            = channel_index;
            channel_index_next = channel_index + 1'b1;
            if (inp_wrap) begin
              active_mux_input_next = '0;
              if (mux_wrap) begin
                active_mux_next    = '0;
                channel_index_next = '0;
                pass_count_next    = pass_count + 1'b1;
              end else begin
                active_mux_next = mux_inc;
              end
            end else begin
              active_mux_input_next = inp_inc;
            end
          end
          s0_start = !(pass_count_next >= sample_passes);
        end
      end
      CMD_READ: begin
        s0_op = OP_READ;
      end
      CMD_RESTART: begin
        pass_count_next    = '0;
        channel_index_next = '0;
        s0_start           = sample_passes != '0;
      end
      default: ;
    endcase
    s0_avail = pass_count_next >= sample_passes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_index    <= '0;
      active_mux       <= '0;
      active_mux_input <= '0;
      pass_count       <= '0;
      discard_next     <= 1'b1;
    end else if (accept) begin
      channel_index    <= channel_index_next;
      active_mux       <= active_mux_next;
      active_mux_input <= active_mux_input_next;
      pass_count       <= pass_count_next;
      discard_next     <= discard_next_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulator memory: one read at accept, one write from stage 1.
  // Valid bits give the all-zero reset without a clearing pass.
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0]     acc_mem [ACC_DEPTH];
  logic [ACC_DEPTH-1:0] acc_vld;
  logic [ACC_W-1:0]     rd_data;
  logic                 rd_vld;
  logic                 mem_we;
  logic [ACC_W-1:0]     mem_wdata;

  // Stage 1 registers
  op_t                s1_op;
  logic [ACC_AW-1:0]  s1_addr;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [SHIFT_W-1:0] s1_shift;
  logic               s1_avail;
  logic               s1_start;
  logic [MUX_W-1:0]   s1_mux;
  logic [INP_W-1:0]   s1_inp;
  logic               s1_fwd;
  logic [ACC_W-1:0]   fwd_data;

  assign mem_we = s1_adv && (s1_op != OP_NONE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      acc_mem[s1_addr] <= mem_wdata;
    end
    if (accept) begin
      rd_data <= acc_mem[s0_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (mem_we) begin
        acc_vld[s1_addr] <= 1'b1;
      end
      if (accept) begin
        rd_vld <= acc_vld[s0_addr];
      end
    end
  end

  // Stage 1 capture; a write to the same entry at the accept edge is forwarded.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      s1_fwd   <= mem_we && (s1_addr == s0_addr);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= s0_op;
      s1_addr   <= s0_addr;
      s1_sample <= sample & SMASK;
      s1_shift  <= sample_shift;
      s1_avail  <= s0_avail;
      s1_start  <= s0_start;
      s1_mux    <= active_mux_next;
      s1_inp    <= active_mux_input_next;
    end
    if (mem_we) begin
      fwd_data <= mem_wdata;
    end
  end

  // Stage 1 modify
  logic [ACC_W-1:0] acc_cur;
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] s1_read_value;

  assign acc_cur = s1_fwd ? fwd_data : (rd_vld ? rd_data : '0);
  assign acc_sum = {1'b0, acc_cur} + (ACC_W + 1)'(s1_sample);

  always_comb begin
    mem_wdata     = '0;
    s1_read_value = '0;
    case (s1_op)
      OP_ADD: begin
        mem_wdata = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
      end
      OP_READ: begin
        // read clears the entry
        s1_read_value = acc_cur >> s1_shift;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_value       <= s1_read_value;
      data_available   <= s1_avail;
      start_conversion <= s1_start;
      mux_select       <= s1_mux;
      mux_input_select <= s1_inp;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_mux_in_range: assert property (@(posedge clk) disable iff (rst)
    (int'(active_mux) < NUM_MUX) && (int'(active_mux_input) < MUX_INPUTS))
    else $error("scan position out of range");

  a_fwd_needs_stage: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> s1_valid)
    else $error("forward flag without an item in stage 1");

  a_discard_toggles: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_SAMPLE && !stopped) |=> (discard_next != $past(discard_next)))
    else $error("discard flag did not alternate");

  a_stopped_holds_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_SAMPLE && stopped) |=>
      ($stable(channel_index) && $stable(active_mux) && $stable(active_mux_input)))
    else $error("sample after stop moved the scan");

  a_read_writes_back: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_op == OP_READ) |=> (acc_vld[$past(s1_addr)] && !s1_fwd || s1_valid))
    else $error("read did not clear its entry");

endmodule
